// ----- hw/rtl/dbsud_pkg.sv -----
// ----------------------------------------------------------------------------
// dbsud_pkg
// Shared types and constants of the diagnostic bus slave.
// ----------------------------------------------------------------------------
package dbsud_pkg;

   localparam int RAM_DEPTH_DEF  = 256;
   localparam int MAX_UPLOAD_DEF = 62;

   localparam logic [7:0]  ADDR_HASH_LIMIT = 8'h10;
   localparam logic [7:0]  ADDR_UP_HEAD    = 8'h11;
   localparam logic [7:0]  DL_START        = 8'h10;
   localparam logic [31:0] HASH_MOD        = 32'hFFFF_FFFB;
   localparam logic [4:0]  HALT_BOARD      = 5'd2;
   localparam logic [7:0]  HALT_BIT        = 8'h80;

   localparam logic [3:0] CMD_STATUS   = 4'h0;
   localparam logic [3:0] CMD_UPLOAD   = 4'h2;
   localparam logic [3:0] CMD_RESET    = 4'h8;
   localparam logic [3:0] CMD_DOWNLOAD = 4'hA;

   localparam logic [1:0] CSR_BOARD_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_STATUS_CODE   = 2'd1;
   localparam logic [1:0] CSR_RESET_CODE    = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT_CODE  = 2'd3;

   typedef enum logic [2:0] {
      OP_STATUS  = 3'd0,
      OP_RESET   = 3'd1,
      OP_UP_PTR  = 3'd2,
      OP_UP_CNT  = 3'd3,
      OP_DL_CNT  = 3'd4,
      OP_DL_DATA = 3'd5,
      OP_DL_SUM  = 3'd6
   } op_code_type;

   // flag: halted for status, clamp for upload count, last for download data
   typedef struct packed {
      op_code_type code;
      logic [7:0]  data;
      logic        flag;
   } op_type;

   typedef struct packed {
      logic [4:0] board_address;
      logic [7:0] status_code;
      logic [7:0] reset_code;
      logic [7:0] timeout_code;
   } csr_type;

endpackage

// ----- hw/rtl/dbsud_front.sv -----
// ----------------------------------------------------------------------------
// dbsud_front
// Bus word decoder: tracks the command phase and emits operations.
// ----------------------------------------------------------------------------
module dbsud_front #(
   parameter int MAX_UPLOAD = dbsud_pkg::MAX_UPLOAD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              is_address,
   input  logic [7:0]        bus_byte,
   input  logic              seq_halted,
   input  logic [4:0]        board_address,
   output logic              push,
   output dbsud_pkg::op_type push_op
);
   import dbsud_pkg::*;

   typedef enum logic [5:0] {
      F_IDLE    = 6'b000001,
      F_UP_PTR  = 6'b000010,
      F_UP_CNT  = 6'b000100,
      F_DL_CNT  = 6'b001000,
      F_DL_DATA = 6'b010000,
      F_DL_SUM  = 6'b100000
   } fstate_type;

   localparam logic [7:0] MaxUp = 8'(MAX_UPLOAD);

   fstate_type phase_ff, phase_in;
   logic [7:0] left_ff, left_in;
   logic       hit;

   assign hit = is_address && (bus_byte[4:0] == board_address);

   always_comb begin
      phase_in     = phase_ff;
      left_in      = left_ff;
      push         = 1'b0;
      push_op.code = OP_STATUS;
      push_op.data = bus_byte;
      push_op.flag = 1'b0;
      if (accept) begin
         case (phase_ff)
            F_IDLE: begin
               if (hit) begin
                  case (bus_byte[7:4])
                     CMD_STATUS: begin
                        push         = 1'b1;
                        push_op.flag = seq_halted;
                     end
                     CMD_UPLOAD:   phase_in = F_UP_PTR;
                     CMD_RESET: begin
                        push         = 1'b1;
                        push_op.code = OP_RESET;
                     end
                     CMD_DOWNLOAD: phase_in = F_DL_CNT;
                     default: ;
                  endcase
               end
            end
            F_UP_PTR: begin
               push         = 1'b1;
               push_op.code = OP_UP_PTR;
               phase_in     = F_UP_CNT;
            end
            F_UP_CNT: begin
               push         = 1'b1;
               push_op.code = OP_UP_CNT;
               if (bus_byte > MaxUp) begin
                  push_op.data = MaxUp;
                  push_op.flag = 1'b1;
               end
               phase_in = F_IDLE;
            end
            F_DL_CNT: begin
               push         = 1'b1;
               push_op.code = OP_DL_CNT;
               left_in      = bus_byte;
               phase_in     = (bus_byte == 8'd0) ? F_DL_SUM : F_DL_DATA;
            end
            F_DL_DATA: begin
               push         = 1'b1;
               push_op.code = OP_DL_DATA;
               push_op.flag = (left_ff == 8'd1);
               left_in      = left_ff - 8'd1;
               if (left_ff == 8'd1) phase_in = F_DL_SUM;
            end
            F_DL_SUM: begin
               push         = 1'b1;
               push_op.code = OP_DL_SUM;
               phase_in     = F_IDLE;
            end
            default: phase_in = F_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= F_IDLE;
         left_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

// ----- hw/rtl/dbsud_queue.sv -----
// ----------------------------------------------------------------------------
// dbsud_queue
// Two-entry operation queue between decoder and executor.
// ----------------------------------------------------------------------------
module dbsud_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dbsud_pkg::op_type push_op,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output dbsud_pkg::op_type head_op
);
   import dbsud_pkg::*;

   op_type     slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_op    = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- hw/rtl/dbsud_back.sv -----
// ----------------------------------------------------------------------------
// dbsud_back
// Executor: data RAM, upload sequencer, download sum and hash, result register.
// ----------------------------------------------------------------------------
module dbsud_back #(
   parameter int RAM_DEPTH = dbsud_pkg::RAM_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  dbsud_pkg::csr_type csr,
   input  logic               head_valid,
   input  dbsud_pkg::op_type  head_op,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_result_kind,
   output logic [7:0]         rsp_reply_byte,
   output logic               rsp_is_last,
   output logic               rsp_checksum_ok,
   output logic [31:0]        rsp_download_hash,
   output logic               rsp_count_clamped
);
   import dbsud_pkg::*;

   localparam int AW = $clog2(RAM_DEPTH);

   typedef enum logic [6:0] {
      B_IDLE     = 7'b0000001,
      B_UP_RD    = 7'b0000010,
      B_UP_OUT   = 7'b0000100,
      B_UP_SUM   = 7'b0001000,
      B_HASH_MUL = 7'b0010000,
      B_HASH_RED = 7'b0100000,
      B_DL_DONE  = 7'b1000000
   } bstate_type;

   logic [7:0]           ram [RAM_DEPTH];
   logic [RAM_DEPTH-1:0] vld_ff;

   bstate_type  st_ff, st_in;
   logic [7:0]  ptr_ff, ptr_in, cnt_ff, cnt_in, sum_ff, sum_in;
   logic [7:0]  pend_ff, pend_in, r10_ff, r10_in, hb_ff, hb_in;
   logic        first_ff, first_in, clamp_ff, clamp_in;
   logic        fin_ff, fin_in, chk_ff, chk_in;
   logic [31:0] hash_ff, hash_in;
   logic [34:0] mul_ff, mul_in;
   logic [7:0]  rd_data_ff;
   logic        rd_vld_ff, rd_en;
   logic [7:0]  rd_addr, rd_byte;
   logic        wr_en;
   logic [32:0] red_t, red_s;
   logic [7:0]  stat;
   logic        out_free, load;
   logic        kind_in, last_in, ok_in, oclamp_in;
   logic [7:0]  byte_in;
   logic [31:0] ohash_in;

   logic        valid_ff;
   logic        kind_ff, last_ff, ok_ff, oclamp_ff;
   logic [7:0]  byte_ff;
   logic [31:0] ohash_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign rd_byte  = rd_vld_ff ? rd_data_ff : 8'd0;
   assign rd_addr  = first_ff ? ADDR_UP_HEAD : ptr_ff;
   assign rd_en    = (st_ff == B_UP_RD);
   assign wr_en    = pop && (head_op.code == OP_DL_DATA);

   // fold modulo 2^32-5: 2^32 is congruent to 5
   assign red_t = {1'b0, mul_ff[31:0]} + {28'd0, mul_ff[34:32], 2'b00}
                + {30'd0, mul_ff[34:32]};
   assign red_s = red_t - {1'b0, HASH_MOD};

   always_comb begin
      stat = (pend_ff != 8'd0 && csr.status_code != csr.timeout_code)
           ? pend_ff : csr.status_code;
      if (csr.board_address == HALT_BOARD && head_op.flag) stat = stat | HALT_BIT;
   end

   always_comb begin
      st_in     = st_ff;
      ptr_in    = ptr_ff;
      cnt_in    = cnt_ff;
      sum_in    = sum_ff;
      pend_in   = pend_ff;
      r10_in    = r10_ff;
      hb_in     = hb_ff;
      first_in  = first_ff;
      clamp_in  = clamp_ff;
      fin_in    = fin_ff;
      chk_in    = chk_ff;
      hash_in   = hash_ff;
      mul_in    = mul_ff;
      pop       = 1'b0;
      load      = 1'b0;
      kind_in   = 1'b0;
      byte_in   = 8'd0;
      last_in   = 1'b0;
      ok_in     = 1'b0;
      ohash_in  = 32'd0;
      oclamp_in = 1'b0;
      case (st_ff)
         B_IDLE: begin
            if (head_valid && (head_op.code != OP_STATUS || out_free)) begin
               pop = 1'b1;
               case (head_op.code)
                  OP_STATUS: begin
                     load    = 1'b1;
                     byte_in = stat;
                     last_in = 1'b1;
                     pend_in = 8'd0;
                  end
                  OP_RESET:  pend_in = csr.reset_code;
                  OP_UP_PTR: ptr_in  = head_op.data;
                  OP_UP_CNT: begin
                     cnt_in   = head_op.data;
                     clamp_in = head_op.flag;
                     first_in = 1'b1;
                     sum_in   = 8'd0;
                     st_in    = B_UP_RD;
                  end
                  OP_DL_CNT: begin
                     ptr_in  = DL_START;
                     sum_in  = head_op.data;
                     hash_in = {24'd0, head_op.data};
                  end
                  OP_DL_DATA: begin
                     sum_in = sum_ff + head_op.data;
                     ptr_in = ptr_ff + 8'd1;
                     if (ptr_ff == ADDR_HASH_LIMIT) r10_in = head_op.data;
                     if (!head_op.flag
                         && (ptr_ff <= ADDR_HASH_LIMIT || ptr_ff >= r10_ff)) begin
                        hb_in  = head_op.data;
                        fin_in = 1'b0;
                        st_in  = B_HASH_MUL;
                     end
                  end
                  OP_DL_SUM: begin
                     hb_in  = 8'd0;
                     fin_in = 1'b1;
                     chk_in = (sum_ff == head_op.data);
                     st_in  = B_HASH_MUL;
                  end
                  default: ;
               endcase
            end
         end
         B_UP_RD: st_in = B_UP_OUT;
         B_UP_OUT: begin
            if (out_free) begin
               load      = 1'b1;
               byte_in   = rd_byte;
               oclamp_in = clamp_ff;
               sum_in    = sum_ff + rd_byte;
               first_in  = 1'b0;
               if (first_ff) begin
                  st_in = (cnt_ff == 8'd0) ? B_UP_SUM : B_UP_RD;
               end else begin
                  ptr_in = ptr_ff + 8'd1;
                  cnt_in = cnt_ff - 8'd1;
                  st_in  = (cnt_ff == 8'd1) ? B_UP_SUM : B_UP_RD;
               end
            end
         end
         B_UP_SUM: begin
            if (out_free) begin
               load      = 1'b1;
               byte_in   = sum_ff;
               last_in   = 1'b1;
               oclamp_in = clamp_ff;
               st_in     = B_IDLE;
            end
         end
         B_HASH_MUL: begin
            mul_in = {1'b0, hash_ff, 2'b00} + {3'd0, hash_ff} + {27'd0, hb_ff};
            st_in  = B_HASH_RED;
         end
         B_HASH_RED: begin
            hash_in = red_s[32] ? red_t[31:0] : red_s[31:0];
            st_in   = fin_ff ? B_DL_DONE : B_IDLE;
         end
         B_DL_DONE: begin
            if (out_free) begin
               load     = 1'b1;
               kind_in  = 1'b1;
               last_in  = 1'b1;
               ok_in    = chk_ff;
               ohash_in = hash_ff;
               st_in    = B_IDLE;
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

   // data RAM, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) ram[ptr_ff[AW-1:0]] <= head_op.data;
      if (rd_en) rd_data_ff <= ram[rd_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) vld_ff[ptr_ff[AW-1:0]] <= 1'b1;
         if (rd_en) rd_vld_ff <= vld_ff[rd_addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= B_IDLE;
         ptr_ff   <= 8'd0;
         cnt_ff   <= 8'd0;
         sum_ff   <= 8'd0;
         pend_ff  <= 8'd0;
         r10_ff   <= 8'd0;
         hash_ff  <= 32'd0;
         first_ff <= 1'b0;
         clamp_ff <= 1'b0;
         fin_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         ptr_ff   <= ptr_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         pend_ff  <= pend_in;
         r10_ff   <= r10_in;
         hash_ff  <= hash_in;
         first_ff <= first_in;
         clamp_ff <= clamp_in;
         fin_ff   <= fin_in;
         if (load) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      hb_ff  <= hb_in;
      chk_ff <= chk_in;
      mul_ff <= mul_in;
      if (load) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         last_ff   <= last_in;
         ok_ff     <= ok_in;
         ohash_ff  <= ohash_in;
         oclamp_ff <= oclamp_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_reply_byte    = byte_ff;
   assign rsp_is_last       = last_ff;
   assign rsp_checksum_ok   = ok_ff;
   assign rsp_download_hash = ohash_ff;
   assign rsp_count_clamped = oclamp_ff;

endmodule

// ----- hw/rtl/diag_bus_slave_upload_download.sv -----
// ----------------------------------------------------------------------------
// diag_bus_slave_upload_download
// Diagnostic bus slave with 256-byte data RAM, upload and download commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one 9-bit bus word per handshake (req_is_address is bit 8).
//   rsp_* carries result words: reply bytes (result_kind 0) or the download
//   completion report (result_kind 1); rsp_is_last closes each run.
//   csr_* writes board_address, status_code, reset_code, timeout_code; the user
//   must write them only while the block is idle: the block does not enforce it.
// Timing:
//   A decoder takes one word per cycle, while the queue is not full, into a
//   two-entry operation queue; the executor drains it. A hashed download
//   byte goes through multiply-by-five, then reduce modulo 0xFFFFFFFB; an
//   upload emits each byte by a registered RAM read, then an output load.
//   A reply passes the queue slot, then the result register.
// Reset: all control state, the pending reply and the RAM valid bits clear at
//   once; the RAM reads as zero until written. No clearing pass is needed.
// Stall: rsp_ready held low freezes the executor at its next result; the
//   queue then fills and req_ready drops.
// ----------------------------------------------------------------------------
module diag_bus_slave_upload_download #(
   parameter int RAM_DEPTH  = dbsud_pkg::RAM_DEPTH_DEF,
   parameter int MAX_UPLOAD = dbsud_pkg::MAX_UPLOAD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_is_address,
   input  logic [7:0]  req_bus_byte,
   input  logic        req_seq_halted,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_reply_byte,
   output logic        rsp_is_last,
   output logic        rsp_checksum_ok,
   output logic [31:0] rsp_download_hash,
   output logic        rsp_count_clamped,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import dbsud_pkg::*;

   csr_type csr_ff;
   op_type  push_op, head_op;
   logic    push, full, pop, head_valid, accept;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.board_address <= 5'd2;
         csr_ff.status_code   <= 8'd0;
         csr_ff.reset_code    <= 8'd1;
         csr_ff.timeout_code  <= 8'd2;
      end else if (csr_we && !csr_index[2]) begin
         case (csr_index[1:0])
            CSR_BOARD_ADDRESS: csr_ff.board_address <= csr_wdata[4:0];
            CSR_STATUS_CODE:   csr_ff.status_code   <= csr_wdata;
            CSR_RESET_CODE:    csr_ff.reset_code    <= csr_wdata;
            CSR_TIMEOUT_CODE:  csr_ff.timeout_code  <= csr_wdata;
            default: ;
         endcase
      end
   end

   dbsud_front #(.MAX_UPLOAD(MAX_UPLOAD)) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .is_address    (req_is_address),
      .bus_byte      (req_bus_byte),
      .seq_halted    (req_seq_halted),
      .board_address (csr_ff.board_address),
      .push          (push),
      .push_op       (push_op)
   );

   dbsud_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   dbsud_back #(.RAM_DEPTH(RAM_DEPTH)) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr               (csr_ff),
      .head_valid        (head_valid),
      .head_op           (head_op),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_reply_byte    (rsp_reply_byte),
      .rsp_is_last       (rsp_is_last),
      .rsp_checksum_ok   (rsp_checksum_ok),
      .rsp_download_hash (rsp_download_hash),
      .rsp_count_clamped (rsp_count_clamped)
   );

endmodule

// ----- hw/rtl/dbsud_checker.sv -----
// ----------------------------------------------------------------------------
// dbsud_checker
// Port-level checks of the diagnostic bus slave result channel.
// ----------------------------------------------------------------------------
module dbsud_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_kind,
   input logic        rsp_is_last,
   input logic        rsp_checksum_ok,
   input logic [31:0] rsp_download_hash,
   input logic        rsp_count_clamped
);
   import dbsud_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_report_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |-> rsp_is_last && !rsp_count_clamped)
      else $error("download report must close its run");

   a_hash_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |-> rsp_download_hash < HASH_MOD)
      else $error("hash not reduced");

   a_reply_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind |-> !rsp_checksum_ok && rsp_download_hash == 32'd0)
      else $error("reply word carries report fields");

endmodule

bind diag_bus_slave_upload_download dbsud_checker u_dbsud_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_is_last       (rsp_is_last),
   .rsp_checksum_ok   (rsp_checksum_ok),
   .rsp_download_hash (rsp_download_hash),
   .rsp_count_clamped (rsp_count_clamped)
);
